>>> sv/aesbcm_pkg.sv
// Shared types, constants, substitution tables and round functions for the AES block.
package aesbcm_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int KEY_ROWS        = ROUND_KEY_WORDS / 4;
    localparam int ROW_AW          = $clog2(KEY_ROWS);
    localparam int WORD_AW         = $clog2(ROUND_KEY_WORDS);

    // longest key length whose schedule fits the key memory
    localparam logic [1:0] MAX_SEL = (ROUND_KEY_WORDS >= 60) ? 2'd2 :
                                     (ROUND_KEY_WORDS >= 52) ? 2'd1 : 2'd0;

    localparam logic [7:0]  GF_POLY   = 8'h1b;
    localparam logic [7:0]  INV_M0    = 8'h0e;
    localparam logic [7:0]  INV_M1    = 8'h0b;
    localparam logic [7:0]  INV_M2    = 8'h0d;
    localparam logic [7:0]  INV_M3    = 8'h09;
    localparam logic [7:0]  FWD_M0    = 8'h02;
    localparam logic [7:0]  FWD_M1    = 8'h03;
    localparam logic [7:0]  FWD_M2    = 8'h01;
    localparam logic [7:0]  FWD_M3    = 8'h01;
    localparam logic [31:0] RCON_BASE = 32'h0100_0000;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KEYLEN = 3'd4,
        REG_OP     = 3'd5,
        REG_IVHI   = 3'd6,
        REG_IVLO   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_ECB_ENC = 3'd0,
        OP_ECB_DEC = 3'd1,
        OP_CBC_ENC = 3'd2,
        OP_CBC_DEC = 3'd3,
        OP_CTR     = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPAND = 5'b00010,
        ST_KREAD  = 5'b00100,
        ST_CRYPT  = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p  = 8'h00;
        aa = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ aa;
            end
            aa = xtime(aa);
        end
        return p;
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 sits in the top bits; byte 4*c+r is row r of column c
    function automatic block_t sub_shift(input block_t s, input logic inv);
        block_t t;
        int     src;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                begin
                    src = 4 * ((c + 4 - r) % 4) + r;
                    t[127 - 8 * (4 * c + r) -: 8] = SBOX_REV[s[127 - 8 * src -: 8]];
                end
                else
                begin
                    src = 4 * ((c + r) % 4) + r;
                    t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * src -: 8]];
                end
            end
        end
        return t;
    endfunction

    function automatic block_t mix(input block_t s, input logic inv);
        block_t     t;
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [7:0] v;
        t = '0;
        if (inv)
        begin
            m = '{INV_M0, INV_M1, INV_M2, INV_M3};
        end
        else
        begin
            m = '{FWD_M0, FWD_M1, FWD_M2, FWD_M3};
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a[k] = s[127 - 8 * (4 * c + k) -: 8];
            end
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                begin
                    v = v ^ gmul(a[k], m[(k + 4 - r) % 4]);
                end
                t[127 - 8 * (4 * c + r) -: 8] = v;
            end
        end
        return t;
    endfunction

endpackage

>>> sv/aes_block_cipher_modes.sv
// AES-128/192/256 block engine with ECB, CBC and CTR modes and an in-block key schedule.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tdata: data_high, data_low, valid_bytes
//            |           |                    | tlast: last_block
//  m_*       | out       | m_tvalid/m_tready  | tdata: result_high, result_low,
//            |           |                    |        result_bytes; tlast: result_last
//  cfg_*     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  One word at a time. A cipher word passes through the shared round unit,
//  which reads one round-key row a cycle from the key memory. The first word
//  of a message first runs the key schedule, one key word a cycle.
//  Pass-through words skip the round unit. A finished word waits in the
//  output register; the next word is taken while it waits. Reset clears all
//  control state; the key memory is left undefined, as the schedule rewrites
//  it at every message start.
module aes_block_cipher_modes
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // data_high[63:0], data_low[127:64], valid_bytes[132:128]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // result_high[63:0], result_low[127:64],
                                    // result_bytes[132:128]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    // configuration
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, ivhi_reg, ivlo_reg;
    logic [1:0]  keylen_reg;
    logic [2:0]  op_cfg_reg;

    // control
    aesbcm_pkg::state_t state_reg, state_next;
    logic               in_message_reg, keys_ready_reg;
    logic               out_valid_reg;
    logic [63:0]        counter_reg;
    aesbcm_pkg::block_t chain_reg;

    // word in flight
    aesbcm_pkg::block_t blk_reg, aes_reg;
    logic [4:0]         n_reg;
    logic               last_reg, cry_reg;
    logic [2:0]         op_reg;
    logic [3:0]         rnd_reg, rounds_reg, nk_reg;

    // key schedule
    logic [aesbcm_pkg::WORD_AW-1:0] kidx_reg;
    logic [2:0]                     kc_reg;
    logic [7:0]                     rcon_reg;
    aesbcm_pkg::word_t              win_reg [8];
    logic [95:0]                    row_reg;

    // key memory
    aesbcm_pkg::block_t rk_mem [aesbcm_pkg::KEY_ROWS];
    aesbcm_pkg::block_t rk_q;
    logic                          rd_en;
    logic [aesbcm_pkg::ROW_AW-1:0] rd_addr;

    // output register
    aesbcm_pkg::block_t res_reg;
    logic [4:0]         res_bytes_reg;
    logic               res_last_reg;

    logic               accept, fin_go, dec;
    logic [4:0]         n_in;
    logic               cry_in;
    logic [1:0]         sel_raw, sel;
    aesbcm_pkg::word_t  kw [8];
    aesbcm_pkg::word_t  w_new, w_tmp;
    logic [5:0]         total_words;
    logic               exp_done;
    logic [3:0]         rd_round;
    aesbcm_pkg::block_t ctr_blk, crypt_in, ss, round_out, res_pre, res_mask;
    aesbcm_pkg::block_t in_blk;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == aesbcm_pkg::ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign fin_go    = !out_valid_reg || m_tready;
    assign dec       = (op_reg == aesbcm_pkg::OP_ECB_DEC) || (op_reg == aesbcm_pkg::OP_CBC_DEC);

    assign in_blk = {s_tdata[63:0], s_tdata[127:64]};
    assign n_in   = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
    assign cry_in = (op_cfg_reg == aesbcm_pkg::OP_CTR)
                 || ((n_in == 5'd16) && (op_cfg_reg <= aesbcm_pkg::OP_CBC_DEC));
    assign sel_raw = keylen_reg[1] ? 2'd2 : keylen_reg;
    // fall back to a shorter key when the schedule would not fit
    assign sel     = (sel_raw > aesbcm_pkg::MAX_SEL) ? aesbcm_pkg::MAX_SEL : sel_raw;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            ivhi_reg   <= '0;
            ivlo_reg   <= '0;
            keylen_reg <= '0;
            op_cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (aesbcm_pkg::cfg_reg_t'(cfg_index))
                aesbcm_pkg::REG_KEY0:   key0_reg   <= cfg_data;
                aesbcm_pkg::REG_KEY1:   key1_reg   <= cfg_data;
                aesbcm_pkg::REG_KEY2:   key2_reg   <= cfg_data;
                aesbcm_pkg::REG_KEY3:   key3_reg   <= cfg_data;
                aesbcm_pkg::REG_KEYLEN: keylen_reg <= cfg_data[1:0];
                aesbcm_pkg::REG_OP:     op_cfg_reg <= cfg_data[2:0];
                aesbcm_pkg::REG_IVHI:   ivhi_reg   <= cfg_data;
                aesbcm_pkg::REG_IVLO:   ivlo_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // ---------------- key schedule word ----------------
    assign kw = '{key0_reg[63:32], key0_reg[31:0], key1_reg[63:32], key1_reg[31:0],
                  key2_reg[63:32], key2_reg[31:0], key3_reg[63:32], key3_reg[31:0]};
    assign total_words = 6'(({2'b00, rounds_reg} + 6'd1) << 2);
    assign exp_done    = (kidx_reg == aesbcm_pkg::WORD_AW'(total_words - 6'd1));

    always_comb
    begin
        w_tmp = win_reg[0];
        if (kc_reg == 3'd0)
        begin
            w_tmp = aesbcm_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                  ^ (aesbcm_pkg::RCON_BASE * {24'd0, rcon_reg});
        end
        else if ((nk_reg == 4'd8) && (kc_reg == 3'd4))
        begin
            w_tmp = aesbcm_pkg::sub_word(win_reg[0]);
        end
        if (kidx_reg < aesbcm_pkg::WORD_AW'(nk_reg))
        begin
            w_new = kw[kidx_reg[2:0]];
        end
        else
        begin
            w_new = win_reg[3'(nk_reg - 4'd1)] ^ w_tmp;
        end
    end

    // ---------------- key memory ----------------
    // schedule writes and round reads never share a cycle (state interlock)
    always_comb
    begin
        rd_round = 4'd0;
        rd_en    = 1'b0;
        if (state_reg == aesbcm_pkg::ST_KREAD)
        begin
            rd_en    = 1'b1;
            rd_round = 4'd0;
        end
        else if ((state_reg == aesbcm_pkg::ST_CRYPT) && (rnd_reg < rounds_reg))
        begin
            rd_en    = 1'b1;
            rd_round = rnd_reg + 4'd1;
        end
        rd_addr = aesbcm_pkg::ROW_AW'(dec ? (rounds_reg - rd_round) : rd_round);
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == aesbcm_pkg::ST_EXPAND) && (kidx_reg[1:0] == 2'd3))
        begin
            rk_mem[kidx_reg[aesbcm_pkg::WORD_AW-1:2]] <= {row_reg, w_new};
        end
        if (rd_en)
        begin
            rk_q <= rk_mem[rd_addr];
        end
    end

    // ---------------- round unit ----------------
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ctr_blk[63 - 8 * i -: 8] = counter_reg[8 * i +: 8];
        end
        ctr_blk[127:64] = chain_reg[127:64];
        case (op_reg)
            aesbcm_pkg::OP_CTR:     crypt_in = ctr_blk;
            aesbcm_pkg::OP_CBC_ENC: crypt_in = blk_reg ^ chain_reg;
            default:                crypt_in = blk_reg;
        endcase
    end

    assign ss = aesbcm_pkg::sub_shift(aes_reg, dec);

    always_comb
    begin
        if (rnd_reg == 4'd0)
        begin
            round_out = aes_reg ^ rk_q;
        end
        else if (rnd_reg == rounds_reg)
        begin
            round_out = ss ^ rk_q;
        end
        else if (dec)
        begin
            round_out = aesbcm_pkg::mix(ss ^ rk_q, 1'b1);
        end
        else
        begin
            round_out = aesbcm_pkg::mix(ss, 1'b0) ^ rk_q;
        end
    end

    // ---------------- result ----------------
    always_comb
    begin
        if (!cry_reg)
        begin
            res_pre = blk_reg;
        end
        else
        begin
            case (op_reg)
                aesbcm_pkg::OP_CTR:     res_pre = blk_reg ^ aes_reg;
                aesbcm_pkg::OP_CBC_DEC: res_pre = aes_reg ^ chain_reg;
                default:                res_pre = aes_reg;
            endcase
        end
        // drop bytes at and beyond the byte count
        for (int b = 0; b < 16; b++)
        begin
            res_mask[127 - 8 * b -: 8] = (5'(b) < n_reg) ? res_pre[127 - 8 * b -: 8] : 8'h00;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aesbcm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_message_reg)
                    begin
                        state_next = aesbcm_pkg::ST_EXPAND;
                    end
                    else
                    begin
                        state_next = cry_in ? aesbcm_pkg::ST_KREAD : aesbcm_pkg::ST_FIN;
                    end
                end
            end
            aesbcm_pkg::ST_EXPAND:
            begin
                if (exp_done)
                begin
                    state_next = cry_reg ? aesbcm_pkg::ST_KREAD : aesbcm_pkg::ST_FIN;
                end
            end
            aesbcm_pkg::ST_KREAD:
            begin
                state_next = aesbcm_pkg::ST_CRYPT;
            end
            aesbcm_pkg::ST_CRYPT:
            begin
                if (rnd_reg == rounds_reg)
                begin
                    state_next = aesbcm_pkg::ST_FIN;
                end
            end
            aesbcm_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = aesbcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aesbcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aesbcm_pkg::ST_IDLE;
            in_message_reg <= 1'b0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            counter_reg    <= '0;
            chain_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !in_message_reg)
            begin
                in_message_reg <= 1'b1;
                chain_reg      <= {ivhi_reg, ivlo_reg};
                counter_reg    <= '0;
            end
            if ((state_reg == aesbcm_pkg::ST_EXPAND) && exp_done)
            begin
                keys_ready_reg <= 1'b1;
            end
            if ((state_reg == aesbcm_pkg::ST_FIN) && fin_go)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    in_message_reg <= 1'b0;
                    counter_reg    <= '0;
                    chain_reg      <= '0;
                end
                else
                begin
                    if (op_reg == aesbcm_pkg::OP_CTR)
                    begin
                        counter_reg <= counter_reg + 64'd1;
                    end
                    if (cry_reg && (op_reg == aesbcm_pkg::OP_CBC_ENC))
                    begin
                        chain_reg <= aes_reg;
                    end
                    if (cry_reg && (op_reg == aesbcm_pkg::OP_CBC_DEC))
                    begin
                        chain_reg <= blk_reg;
                    end
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg  <= in_blk;
            n_reg    <= n_in;
            last_reg <= s_tlast;
            op_reg   <= op_cfg_reg;
            cry_reg  <= cry_in;
            if (!in_message_reg)
            begin
                nk_reg     <= 4'd4 + {1'b0, sel, 1'b0};
                rounds_reg <= 4'd10 + {1'b0, sel, 1'b0};
                kidx_reg   <= '0;
                kc_reg     <= '0;
                rcon_reg   <= 8'h01;
            end
        end
        if (state_reg == aesbcm_pkg::ST_EXPAND)
        begin
            kidx_reg   <= kidx_reg + 1'b1;
            kc_reg     <= (kc_reg == 3'(nk_reg - 4'd1)) ? 3'd0 : kc_reg + 3'd1;
            if ((kidx_reg >= aesbcm_pkg::WORD_AW'(nk_reg)) && (kc_reg == 3'd0))
            begin
                rcon_reg <= aesbcm_pkg::xtime(rcon_reg);
            end
            win_reg[0] <= w_new;
            for (int j = 1; j < 8; j++)
            begin
                win_reg[j] <= win_reg[j - 1];
            end
            row_reg <= {row_reg[63:0], w_new};
        end
        if (state_reg == aesbcm_pkg::ST_KREAD)
        begin
            aes_reg <= crypt_in;
            rnd_reg <= 4'd0;
        end
        if (state_reg == aesbcm_pkg::ST_CRYPT)
        begin
            aes_reg <= round_out;
            rnd_reg <= rnd_reg + 4'd1;
        end
        if ((state_reg == aesbcm_pkg::ST_FIN) && fin_go)
        begin
            res_reg       <= res_mask;
            res_bytes_reg <= n_reg;
            res_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_bytes_reg, res_reg[63:0], res_reg[127:64]};
    assign m_tlast  = res_last_reg;

    // ---------------- checks ----------------
    a_keys_before_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aesbcm_pkg::ST_CRYPT) |-> keys_ready_reg)
        else $error("round unit running without an expanded key");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != aesbcm_pkg::ST_IDLE))
        else $error("accepted word did not start processing");

    a_last_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == aesbcm_pkg::ST_FIN) && fin_go && last_reg)
            |=> (!in_message_reg && (counter_reg == 64'd0)))
        else $error("message state not cleared after final word");

    a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == aesbcm_pkg::ST_FIN) && fin_go) |=> m_tvalid)
        else $error("finished word not presented");

endmodule
